@@ rtl/hci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_pkg
// Shared types and encodings of the Hack instruction execute core.
// ----------------------------------------------------------------------------
package hci_pkg;

    localparam int unsigned WORD_W = 16;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [5:0]        comp_t;

    // ALU computation codes (c1..c6)
    localparam comp_t COMP_CONST_ZERO = 6'h2A;
    localparam comp_t COMP_CONST_ONE  = 6'h3F;
    localparam comp_t COMP_NEG_ONE    = 6'h3A;
    localparam comp_t COMP_X          = 6'h0C;
    localparam comp_t COMP_Y          = 6'h30;
    localparam comp_t COMP_NOT_X      = 6'h0D;
    localparam comp_t COMP_NOT_Y      = 6'h31;
    localparam comp_t COMP_NEG_X      = 6'h0F;
    localparam comp_t COMP_NEG_Y      = 6'h33;
    localparam comp_t COMP_X_INC      = 6'h1F;
    localparam comp_t COMP_Y_INC      = 6'h37;
    localparam comp_t COMP_X_DEC      = 6'h0E;
    localparam comp_t COMP_Y_DEC      = 6'h32;
    localparam comp_t COMP_ADD        = 6'h02;
    localparam comp_t COMP_X_SUB_Y    = 6'h13;
    localparam comp_t COMP_Y_SUB_X    = 6'h07;
    localparam comp_t COMP_AND        = 6'h00;
    localparam comp_t COMP_OR         = 6'h15;

    // instruction fields
    localparam int unsigned BIT_C_INSTR = 15;
    localparam int unsigned BIT_A_SEL   = 12;
    localparam int unsigned DEST_M      = 0;
    localparam int unsigned DEST_D      = 1;
    localparam int unsigned DEST_A      = 2;
    localparam int unsigned JMP_GT      = 0;
    localparam int unsigned JMP_EQ      = 1;
    localparam int unsigned JMP_LT      = 2;

    typedef struct packed {
        word_t next_pc;
        word_t a_value;
        word_t d_value;
        logic  mem_write;
        word_t mem_address;
        word_t mem_data;
        logic  halted;
    } result_t;

endpackage

@@ rtl/hci_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_alu
// Hack ALU: the 18 standard computations of D (x) and A or M (y).
// ----------------------------------------------------------------------------
module hci_alu
(
    input  hci_pkg::comp_t code,
    input  hci_pkg::word_t x,
    input  hci_pkg::word_t y,
    output hci_pkg::word_t result,
    output logic           known
);

    always_comb
    begin
        known  = 1'b1;
        result = '0;
        case (code)
            hci_pkg::COMP_CONST_ZERO: result = '0;
            hci_pkg::COMP_CONST_ONE:  result = hci_pkg::word_t'(1);
            hci_pkg::COMP_NEG_ONE:    result = '1;
            hci_pkg::COMP_X:          result = x;
            hci_pkg::COMP_Y:          result = y;
            hci_pkg::COMP_NOT_X:      result = ~x;
            hci_pkg::COMP_NOT_Y:      result = ~y;
            hci_pkg::COMP_NEG_X:      result = '0 - x;
            hci_pkg::COMP_NEG_Y:      result = '0 - y;
            hci_pkg::COMP_X_INC:      result = x + hci_pkg::word_t'(1);
            hci_pkg::COMP_Y_INC:      result = y + hci_pkg::word_t'(1);
            hci_pkg::COMP_X_DEC:      result = x - hci_pkg::word_t'(1);
            hci_pkg::COMP_Y_DEC:      result = y - hci_pkg::word_t'(1);
            hci_pkg::COMP_ADD:        result = x + y;
            hci_pkg::COMP_X_SUB_Y:    result = x - y;
            hci_pkg::COMP_Y_SUB_X:    result = y - x;
            hci_pkg::COMP_AND:        result = x & y;
            hci_pkg::COMP_OR:         result = x | y;
            default:                  known  = 1'b0;
        endcase
    end

endmodule

@@ rtl/hci_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_ram
// Data RAM, one write and one registered read port, write-to-read bypass.
// ----------------------------------------------------------------------------
module hci_ram
#(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  hci_pkg::word_t wr_data,
    input  logic [AW-1:0]  rd_addr,
    output hci_pkg::word_t rd_data
);

    hci_pkg::word_t mem [DEPTH];
    hci_pkg::word_t rd_q_reg;
    hci_pkg::word_t byp_data_reg;
    logic           byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

@@ rtl/hack_cpu_instruction_execute_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hack_cpu_instruction_execute_core
// Hack CPU execute core: A, D, PC registers and data RAM, one instruction
// per transfer, one result per instruction.
// ----------------------------------------------------------------------------
// Executes one instruction per clock cycle unless in_stall is high; its result
// is registered in the output buffer. M is read from a RAM whose registered
// read port always holds RAM[A], readdressed each cycle with the A that the
// current instruction leaves, and bypassed when that cycle writes the same
// word. RAM addresses are A modulo RAM_WORDS. After reset the RAM is zeroed by
// a clearing pass over all RAM_WORDS words, one word per cycle, during which
// in_stall stays high. A two-entry output buffer keeps instructions flowing
// under output stall until both are full, when in_stall rises (as in clearing).
// ----------------------------------------------------------------------------
module hack_cpu_instruction_execute_core
#(
    parameter int unsigned RAM_WORDS = 32768
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic [15:0] a_value,
    output logic [15:0] d_value,
    output logic        mem_write,
    output logic [15:0] mem_address,
    output logic [15:0] mem_data,
    output logic        halted
);

    localparam int unsigned AW      = $clog2(RAM_WORDS);
    localparam bit          IS_POW2 = (RAM_WORDS == (1 << AW));
    localparam int unsigned QB      = 17 - AW;

    // address modulo RAM_WORDS: mask, or restoring reduction over QB steps
    function automatic logic [AW-1:0] ram_idx(input hci_pkg::word_t addr);
        logic [16:0] rem;
        rem = {1'b0, addr};
        if (IS_POW2)
        begin
            return addr[AW-1:0];
        end
        for (int k = QB - 1; k >= 0; k--)
        begin
            if (rem >= (17'(RAM_WORDS) << k))
            begin
                rem = rem - (17'(RAM_WORDS) << k);
            end
        end
        return rem[AW-1:0];
    endfunction

    hci_pkg::word_t  a_reg, a_next;
    hci_pkg::word_t  d_reg, d_next;
    hci_pkg::word_t  pc_reg, pc_next;
    logic            halt_reg, halt_next;
    logic [AW-1:0]   a_idx_reg;
    logic            clearing_reg;
    logic [AW-1:0]   clr_cnt_reg;

    hci_pkg::result_t res;
    hci_pkg::result_t out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    hci_pkg::word_t  mem_y, alu_y, alu_r;
    logic            alu_ok;
    logic            in_fire, out_fire;
    logic            is_c, neg, zero, pos, take;
    logic [2:0]      dest, jmp;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    hci_pkg::word_t  ram_wdata;

    assign in_stall = clearing_reg || skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign is_c  = instruction[hci_pkg::BIT_C_INSTR];
    assign dest  = instruction[5:3];
    assign jmp   = instruction[2:0];
    assign alu_y = instruction[hci_pkg::BIT_A_SEL] ? mem_y : a_reg;

    hci_alu u_alu
    (
        .code   (instruction[11:6]),
        .x      (d_reg),
        .y      (alu_y),
        .result (alu_r),
        .known  (alu_ok)
    );

    assign neg  = alu_r[15];
    assign zero = (alu_r == '0);
    assign pos  = !neg && !zero;
    assign take = (jmp[hci_pkg::JMP_LT] && neg) || (jmp[hci_pkg::JMP_EQ] && zero) ||
                  (jmp[hci_pkg::JMP_GT] && pos);

    always_comb
    begin
        a_next          = a_reg;
        d_next          = d_reg;
        pc_next         = pc_reg;
        halt_next       = halt_reg;
        res.mem_write   = 1'b0;
        res.mem_data    = '0;
        if (in_fire && !halt_reg)
        begin
            if (!is_c)
            begin
                a_next  = instruction;
                pc_next = pc_reg + hci_pkg::word_t'(1);
            end
            else if (!alu_ok)
            begin
                halt_next = 1'b1;
            end
            else
            begin
                if (dest[hci_pkg::DEST_M])
                begin
                    res.mem_write = 1'b1;
                    res.mem_data  = alu_r;
                end
                if (dest[hci_pkg::DEST_D])
                begin
                    d_next = alu_r;
                end
                if (dest[hci_pkg::DEST_A])
                begin
                    a_next = alu_r;
                end
                pc_next = take ? a_reg : pc_reg + hci_pkg::word_t'(1);
            end
        end
        res.next_pc     = pc_next;
        res.a_value     = a_next;
        res.d_value     = d_next;
        res.mem_address = a_reg;
        res.halted      = halt_next;
    end

    // RAM ports: clearing pass after reset, then M writes at the old A
    always_comb
    begin
        ram_we    = clearing_reg || (in_fire && res.mem_write);
        ram_waddr = clearing_reg ? clr_cnt_reg : a_idx_reg;
        ram_wdata = clearing_reg ? '0 : alu_r;
        ram_raddr = ram_idx(a_next);
    end

    hci_ram
    #(
        .DEPTH (RAM_WORDS),
        .AW    (AW)
    )
    u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (mem_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg        <= '0;
            d_reg        <= '0;
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            a_idx_reg    <= '0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            a_reg     <= a_next;
            d_reg     <= d_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            a_idx_reg <= ram_raddr;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(RAM_WORDS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = out_reg.next_pc;
    assign a_value     = out_reg.a_value;
    assign d_value     = out_reg.d_value;
    assign mem_write   = out_reg.mem_write;
    assign mem_address = out_reg.mem_address;
    assign mem_data    = out_reg.mem_data;
    assign halted      = out_reg.halted;

endmodule
